/* rtl/slid_pkg.sv */
// Shared types and constants for the sorted list insert and delete core.
package slid_pkg;

	localparam int CAPACITY = 16;
	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam int VALUE_W = 32;
	localparam int POS_W = 4;
	localparam int ENTRY_COUNT_W = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [VALUE_W-1:0] data_value;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic ins_en;
		logic del_en;
	} cell_cmd_t;

endpackage

/* rtl/sorted_list_insert_delete_core.sv */
// Top level of the sorted list core: cell chain, entry count and output register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data  (opcode, value, position)
//   out      output     out_valid / out_ready out_data (status, data_value, entry_count)
//
// All cells compare against the value in parallel and shift at the same edge,
// so a new beat is taken every cycle while results drain.
// The result sits in an output register; a new beat is taken when it is empty or
// being taken in the same cycle. Reset clears the entry count and the output valid
// flag; cell contents are not cleared and are never read before they are written.
module sorted_list_insert_delete_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input slid_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output slid_pkg::out_item_t out_data
);

	localparam int CAP = slid_pkg::CAPACITY;
	localparam int CW = slid_pkg::COUNT_W;
	localparam int VW = slid_pkg::VALUE_W;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic out_valid_q;
	slid_pkg::out_item_t out_q;
	slid_pkg::out_item_t result;
	slid_pkg::cell_cmd_t cmd;

	logic accept;
	logic full;
	logic found;
	logic signed [VW-1:0] entry [CAP];
	logic [CAP-1:0] occ;
	logic [CAP-1:0] gt;
	logic [CAP-1:0] eq;
	logic signed [VW-1:0] read_data;
	logic read_hit;
	logic [31:0] cnt_wide;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign full = (32'(cnt_q) >= CAP);
	assign found = |eq;

	assign cmd.ins_en = accept && (in_data.opcode == slid_pkg::OP_INSERT) && !full;
	assign cmd.del_en = accept && (in_data.opcode == slid_pkg::OP_DELETE) && found;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic pgt;
		logic signed [VW-1:0] pent;
		logic signed [VW-1:0] nent;

		assign occ[i] = (32'(cnt_q) > 32'(i));

		if (i == 0) begin : g_first
			assign pgt = 1'b0;
			assign pent = in_data.value;
		end else begin : g_mid
			assign pgt = gt[i-1];
			assign pent = entry[i-1];
		end

		if (i == CAP - 1) begin : g_last
			assign nent = entry[i];
		end else begin : g_inner
			assign nent = entry[i+1];
		end

		slid_cell u_cell (
			.clk(clk),
			.cmd(cmd),
			.value(in_data.value),
			.occ(occ[i]),
			.prev_gt(pgt),
			.prev_entry(pent),
			.next_entry(nent),
			.entry(entry[i]),
			.gt(gt[i]),
			.eq(eq[i])
		);
	end

	always_comb begin
		read_data = '0;
		read_hit = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			if ({28'd0, in_data.position} == 32'(i) && occ[i]) begin
				read_data = entry[i];
				read_hit = 1'b1;
			end
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		result.status = slid_pkg::ST_OK;
		result.data_value = '0;
		case (in_data.opcode)
			slid_pkg::OP_INSERT: begin
				if (full) begin
					result.status = slid_pkg::ST_FULL;
				end else begin
					cnt_next = cnt_q + 1'b1;
				end
			end
			slid_pkg::OP_DELETE: begin
				if (found) begin
					cnt_next = cnt_q - 1'b1;
				end else begin
					result.status = slid_pkg::ST_NOT_FOUND;
				end
			end
			slid_pkg::OP_READ: begin
				if (read_hit) begin
					result.data_value = read_data;
				end else begin
					result.status = slid_pkg::ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		cnt_wide = 32'(cnt_next);
		result.entry_count = cnt_wide[slid_pkg::ENTRY_COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= CAP)
		else $error("entry count exceeds capacity");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while output register is empty");

	a_full_insert_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.opcode == slid_pkg::OP_INSERT) && full |=> cnt_q == $past(cnt_q))
		else $error("insert into full table changed the count");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del_en |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("successful delete did not shrink the count");
`endif

endmodule

/* rtl/slid_cell.sv */
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module slid_cell (
	input logic clk,
	input slid_pkg::cell_cmd_t cmd,
	input logic signed [slid_pkg::VALUE_W-1:0] value,
	input logic occ,
	input logic prev_gt,
	input logic signed [slid_pkg::VALUE_W-1:0] prev_entry,
	input logic signed [slid_pkg::VALUE_W-1:0] next_entry,
	output logic signed [slid_pkg::VALUE_W-1:0] entry,
	output logic gt,
	output logic eq
);

	logic signed [slid_pkg::VALUE_W-1:0] entry_q;
	logic ge;

	assign entry = entry_q;
	assign gt = occ && (entry_q > value);
	assign ge = occ && (entry_q >= value);
	assign eq = occ && (entry_q == value);

	// On insert, cells past the slot take their left neighbor and the slot takes the
	// new value. On delete, every occupied cell from the match onward takes its right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (gt || !occ) begin
				entry_q <= value;
			end
		end else if (cmd.del_en && ge) begin
			entry_q <= next_entry;
		end
	end

endmodule

/* bench/tb_sorted_list_insert_delete_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted list insert and delete core.
module tb_sorted_list_insert_delete_core;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_ITEMS = 150;
	localparam int POOL_SIZE = 8;
	localparam logic signed [slid_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [slid_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {
		EP_FILL,
		EP_DRAIN,
		EP_MIXED,
		EP_NOISE
	} episode_kind_t;

	typedef struct {
		slid_pkg::in_item_t item;
		bit drain_first;
	} queued_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	slid_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	slid_pkg::out_item_t out_data;

	queued_op_t op_backlog[$];
	slid_pkg::out_item_t pending_results[$];
	logic signed [slid_pkg::VALUE_W-1:0] shadow_vals [slid_pkg::CAPACITY];
	int shadow_count = 0;
	logic signed [slid_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

	int mismatches = 0;
	int results_checked = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int send_gap = 0;
	int recv_gap = 0;
	bit send_bursty = 1'b1;
	bit recv_bursty = 1'b1;
	bit tail_phase = 1'b0;

	sorted_list_insert_delete_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Applies one operation to the shadow list and returns the result it should give.
	task automatic list_apply(input slid_pkg::in_item_t op, output slid_pkg::out_item_t res);
		int slot;
		int k;
		logic signed [slid_pkg::VALUE_W-1:0] v;
		v = op.value;
		res = '0;
		case (op.opcode)
			slid_pkg::OP_INSERT: begin
				if (shadow_count >= slid_pkg::CAPACITY) begin
					res.status = slid_pkg::ST_FULL;
				end else begin
					slot = 0;
					while (slot < shadow_count && !($signed(shadow_vals[slot]) > $signed(v)))
						slot++;
					for (k = shadow_count; k > slot; k--)
						shadow_vals[k] = shadow_vals[k - 1];
					shadow_vals[slot] = v;
					shadow_count++;
				end
			end
			slid_pkg::OP_DELETE: begin
				slot = 0;
				while (slot < shadow_count && shadow_vals[slot] != v)
					slot++;
				if (slot >= shadow_count) begin
					res.status = slid_pkg::ST_NOT_FOUND;
				end else begin
					for (k = slot; k + 1 < shadow_count; k++)
						shadow_vals[k] = shadow_vals[k + 1];
					shadow_count--;
				end
			end
			slid_pkg::OP_READ: begin
				if (int'(op.position) < shadow_count)
					res.data_value = shadow_vals[op.position];
				else
					res.status = slid_pkg::ST_RANGE;
			end
			default: begin
			end
		endcase
		res.entry_count = shadow_count[slid_pkg::ENTRY_COUNT_W-1:0];
	endtask

	task automatic queue_op(input logic [1:0] op,
			input logic signed [slid_pkg::VALUE_W-1:0] v,
			input logic [slid_pkg::POS_W-1:0] pos, input bit drain);
		queued_op_t q;
		q.item.opcode = op;
		q.item.value = v;
		q.item.position = pos;
		q.drain_first = drain;
		op_backlog.push_back(q);
	endtask

	// A small pool per episode makes duplicates and delete hits common.
	task automatic refresh_pool();
		int i;
		for (i = 0; i < POOL_SIZE; i++) begin
			case ($urandom_range(0, 3))
				0: value_pool[i] = $urandom;
				1: value_pool[i] = $signed($urandom_range(0, 8)) - 4;
				2: value_pool[i] = $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 2)
					: VAL_MIN + $urandom_range(0, 2);
				default: value_pool[i] = $signed($urandom_range(0, 2000)) - 1000;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_ops
		queued_op_t next_op;
		slid_pkg::out_item_t predicted;
		logic next_valid;
		bit slot_free;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
			shadow_count = 0;
		end else begin
			slot_free = !in_valid;
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				list_apply(in_data, predicted);
				pending_results.push_back(predicted);
				slot_free = 1'b1;
				next_valid = 1'b0;
			end
			if (slot_free) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (op_backlog.size() > 0 &&
						!(op_backlog[0].drain_first && !tail_phase &&
						pending_results.size() > 0)) begin
					next_op = op_backlog.pop_front();
					in_data <= next_op.item;
					next_valid = 1'b1;
					if (!tail_phase && send_bursty && $urandom_range(0, 3) == 0)
						send_gap <= $urandom_range(1, 6);
				end
			end
			if ($urandom_range(0, 63) == 0)
				send_bursty <= !send_bursty;
			tail_phase <= (op_backlog.size() < TAIL_ITEMS);
			in_valid <= next_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		slid_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					want = pending_results.pop_front();
					if (out_data.status !== want.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							out_data.status, want.status));
					if (out_data.data_value !== want.data_value)
						flag_mismatch($sformatf("data_value got %0d want %0d",
							out_data.data_value, want.data_value));
					if (out_data.entry_count !== want.entry_count)
						flag_mismatch($sformatf("entry_count got %0d want %0d",
							out_data.entry_count, want.entry_count));
					status_seen[want.status]++;
					results_checked++;
				end
			end
			// A stall burst holds out_ready low until a random gap counter runs out.
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!tail_phase && recv_bursty && $urandom_range(0, 3) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if ($urandom_range(0, 63) == 0)
				recv_bursty <= !recv_bursty;
		end
	end

	initial begin : stimulus
		int random_made;
		int len;
		int i;
		int roll;
		bit hold;
		episode_kind_t kind;
		logic [1:0] op;
		logic signed [slid_pkg::VALUE_W-1:0] v;

		// Empty table: read out of range, delete with nothing held, unused opcode.
		queue_op(slid_pkg::OP_READ, $urandom, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_DELETE, 32'sd5, 4'($urandom_range(0, 15)), 1'b0);
		queue_op(OP_UNUSED, $urandom, 4'd15, 1'b0);
		// Seventeen inserts with extremes and duplicates fill the table; the last one finds it full.
		queue_op(slid_pkg::OP_INSERT, VAL_MIN, 4'd15, 1'b0);
		queue_op(slid_pkg::OP_INSERT, VAL_MAX, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd0, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, -32'sd1, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd1, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, VAL_MAX, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd0, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, VAL_MIN, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd7, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, -32'sd7, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd0, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd100, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, -32'sd100, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd1, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, VAL_MAX - 1, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, VAL_MIN + 1, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_INSERT, 32'sd5, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_READ, 32'sd0, 4'd15, 1'b0);
		queue_op(slid_pkg::OP_READ, 32'sd0, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_DELETE, 32'sd0, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_DELETE, 32'sd12345, 4'd0, 1'b0);
		queue_op(slid_pkg::OP_READ, 32'sd0, 4'd15, 1'b0);

		random_made = 0;
		hold = 1'b1;
		while (random_made < RANDOM_ITEMS) begin
			refresh_pool();
			kind = episode_kind_t'($urandom_range(0, 3));
			len = $urandom_range(20, 60);
			for (i = 0; i < len; i++) begin
				roll = $urandom_range(0, 99);
				case (kind)
					EP_FILL: op = roll < 70 ? slid_pkg::OP_INSERT
						: roll < 80 ? slid_pkg::OP_DELETE
						: roll < 97 ? slid_pkg::OP_READ : OP_UNUSED;
					EP_DRAIN: op = roll < 15 ? slid_pkg::OP_INSERT
						: roll < 75 ? slid_pkg::OP_DELETE
						: roll < 97 ? slid_pkg::OP_READ : OP_UNUSED;
					EP_MIXED: op = roll < 40 ? slid_pkg::OP_INSERT
						: roll < 70 ? slid_pkg::OP_DELETE
						: roll < 97 ? slid_pkg::OP_READ : OP_UNUSED;
					default: op = 2'($urandom_range(0, 3));
				endcase
				if (kind != EP_NOISE && $urandom_range(0, 99) < 85)
					v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					v = $urandom;
				queue_op(op, v, 4'($urandom_range(0, 15)), hold && i == 0);
				random_made++;
			end
			hold = ($urandom_range(0, 7) == 0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() > 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("summary: %0d results checked: %0d ok, %0d not found, %0d full, %0d out of range",
			results_checked, status_seen[slid_pkg::ST_OK], status_seen[slid_pkg::ST_NOT_FOUND],
			status_seen[slid_pkg::ST_FULL], status_seen[slid_pkg::ST_RANGE]);
		$display("summary: %0d mismatches", mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
